@@ design/round_robin_flow_scheduler_unit_macros.svh @@
// Assertion macros used by the round-robin flow scheduler datapath.
`ifndef ROUND_ROBIN_FLOW_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_FLOW_SCHEDULER_UNIT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define RRFS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RRFS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/rrfs_pkg.sv @@
// Shared types and constants of the round-robin flow scheduler.
package rrfs_pkg;

   localparam int MAX_ACTIVE_DEFAULT = 16;

   // Request kinds
   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOW_LIMIT      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_FLOW_LENGTH = 2'd2;

   localparam logic [15:0] MAX_FLOW_LENGTH_RESET = 16'hFFFF;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic pop_read;
      logic insert;
      logic read;
      logic exec;
      logic finish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic kind;
      logic arr_ok;
      logic empty;
      logic out_free;
   } status_type;

endpackage

@@ design/rrfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rrfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rd_ff;

endmodule

@@ design/rrfs_ctrl.sv @@
// Sequencing state machine of the round-robin flow scheduler.
module rrfs_ctrl
   import rrfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DEC  = 6'b000010,
      S_INS  = 6'b000100,
      S_RD   = 6'b001000,
      S_EXE  = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            cmd.pop_read = 1'b1;
            if (st.kind == KIND_ARRIVAL && st.arr_ok) begin
               state_in = S_INS;
            end else if (st.kind == KIND_TICK && !st.empty) begin
               state_in = S_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_INS: begin
            cmd.insert = 1'b1;
            state_in   = st.empty ? S_RD : S_FIN;
         end
         S_RD: begin
            cmd.read = 1'b1;
            state_in = S_EXE;
         end
         S_EXE: begin
            if (st.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

@@ design/rrfs_datapath.sv @@
// Flow list, slot allocation and result register of the scheduler.
module rrfs_datapath
   import rrfs_pkg::*;
#(
   parameter int MAX_ACTIVE = MAX_ACTIVE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  st,
   input  logic        req_kind,
   input  logic [15:0] req_flow_length,
   input  logic        limit_enable,
   input  logic [15:0] flow_limit,
   input  logic [15:0] max_flow_length,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic        rsp_sent,
   output logic [15:0] rsp_flow_tag,
   output logic [15:0] rsp_packet_number,
   output logic        rsp_flow_done,
   output logic [4:0]  rsp_active_flows,
   output logic        rsp_arrival_accepted
);

`include "round_robin_flow_scheduler_unit_macros.svh"

   localparam int AW = $clog2(MAX_ACTIVE);
   localparam int CW = $clog2(MAX_ACTIVE + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ACTIVE);

   // List and allocation state
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in, serve_ff, serve_in;
   logic [CW-1:0] count_ff, count_in, fresh_ff, fresh_in, free_top_ff, free_top_in;
   logic [15:0]   created_ff, created_in;

   // Captured request
   logic          kind_ff;
   logic [15:0]   len_ff;
   logic          acc_ff, acc_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          sent_ff;
   logic [15:0]   tag_ff, pnum_ff;
   logic          done_ff;
   logic [4:0]    active_ff;
   logic          racc_ff;

   // Memory ports
   logic          flow_we, link_we, prev_we, free_we;
   logic [AW-1:0] flow_waddr, link_waddr, prev_waddr;
   logic [47:0]   flow_wdata, flow_rd;
   logic [AW-1:0] link_wdata, prev_wdata, link_rd, prev_rd, free_rd;

   // Working values
   logic          out_free;
   logic [AW-1:0] slot;
   logic [15:0]   sent1;
   logic          done, is_head, is_last;
   logic [AW-1:0] new_head;
   logic [CW-1:0] count_after;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign slot     = (free_top_ff != '0) ? free_rd : fresh_ff[AW-1:0];

   // Served flow update
   assign sent1       = flow_rd[31:16] + 16'd1;
   assign done        = (sent1 >= flow_rd[15:0]);
   assign is_head     = (serve_ff == head_ff);
   assign is_last     = (serve_ff == tail_ff);
   assign new_head    = (done && is_head) ? link_rd : head_ff;
   assign count_after = done ? count_ff - CW'(1) : count_ff;

   // Status to controller
   assign st.kind     = kind_ff;
   assign st.arr_ok   = (len_ff != 16'd0) && !(limit_enable && created_ff >= flow_limit)
                        && (count_ff < COUNT_MAX);
   assign st.empty    = (count_ff == '0);
   assign st.out_free = out_free;

   // Memory write muxes
   assign flow_we    = cmd.insert || cmd.exec;
   assign flow_waddr = cmd.insert ? slot : serve_ff;
   assign flow_wdata = cmd.insert ? {created_ff, 16'd0, len_ff}
                                  : {flow_rd[47:32], sent1, flow_rd[15:0]};
   assign link_we    = cmd.insert || (cmd.exec && done && !is_head);
   assign link_waddr = cmd.insert ? slot : prev_rd;
   assign link_wdata = cmd.insert ? head_ff : link_rd;
   assign prev_we    = (cmd.insert && !st.empty) || (cmd.exec && done && !is_last);
   assign prev_waddr = cmd.insert ? head_ff : link_rd;
   assign prev_wdata = cmd.insert ? slot : prev_rd;
   assign free_we    = cmd.exec && done;

   rrfs_ram #(.WIDTH(48), .DEPTH(MAX_ACTIVE)) u_flow_ram (
      .clock(clock), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
      .re(cmd.read), .raddr(serve_ff), .rdata(flow_rd)
   );

   rrfs_ram #(.WIDTH(AW), .DEPTH(MAX_ACTIVE)) u_link_ram (
      .clock(clock), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .re(cmd.read), .raddr(serve_ff), .rdata(link_rd)
   );

   rrfs_ram #(.WIDTH(AW), .DEPTH(MAX_ACTIVE)) u_prev_ram (
      .clock(clock), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
      .re(cmd.read), .raddr(serve_ff), .rdata(prev_rd)
   );

   // Stack of released slots
   rrfs_ram #(.WIDTH(AW), .DEPTH(MAX_ACTIVE)) u_free_ram (
      .clock(clock), .we(free_we), .waddr(free_top_ff[AW-1:0]), .wdata(serve_ff),
      .re(cmd.pop_read), .raddr(AW'(free_top_ff - CW'(1))), .rdata(free_rd)
   );

   // List state next values
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      serve_in    = serve_ff;
      count_in    = count_ff;
      fresh_in    = fresh_ff;
      free_top_in = free_top_ff;
      created_in  = created_ff;
      acc_in      = acc_ff;
      if (cmd.capture) begin
         acc_in = 1'b0;
      end
      if (cmd.insert) begin
         acc_in  = 1'b1;
         head_in = slot;
         if (st.empty) begin
            tail_in  = slot;
            serve_in = slot;
         end
         count_in = count_ff + CW'(1);
         if (free_top_ff != '0) begin
            free_top_in = free_top_ff - CW'(1);
         end else begin
            fresh_in = fresh_ff + CW'(1);
         end
         if (created_ff != 16'hFFFF) begin
            created_in = created_ff + 16'd1;
         end
      end
      if (cmd.exec) begin
         head_in  = new_head;
         serve_in = is_last ? new_head : link_rd;
         count_in = count_after;
         if (done) begin
            free_top_in = free_top_ff + CW'(1);
            if (is_last && !is_head) begin
               tail_in = prev_rd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         serve_ff    <= '0;
         count_ff    <= '0;
         fresh_ff    <= '0;
         free_top_ff <= '0;
         created_ff  <= '0;
         acc_ff      <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         serve_ff    <= serve_in;
         count_ff    <= count_in;
         fresh_ff    <= fresh_in;
         free_top_ff <= free_top_in;
         created_ff  <= created_in;
         acc_ff      <= acc_in;
      end
   end

   // Request capture, length capped
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         len_ff  <= (req_flow_length > max_flow_length) ? max_flow_length : req_flow_length;
      end
   end

   // Result register
   assign rsp_valid_in = (cmd.exec || cmd.finish) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         sent_ff   <= 1'b1;
         tag_ff    <= flow_rd[47:32];
         pnum_ff   <= sent1;
         done_ff   <= done;
         active_ff <= 5'(count_after);
         racc_ff   <= acc_ff;
      end else if (cmd.finish) begin
         sent_ff   <= 1'b0;
         tag_ff    <= 16'd0;
         pnum_ff   <= 16'd0;
         done_ff   <= 1'b0;
         active_ff <= 5'(count_ff);
         racc_ff   <= acc_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sent             = sent_ff;
   assign rsp_flow_tag         = tag_ff;
   assign rsp_packet_number    = pnum_ff;
   assign rsp_flow_done        = done_ff;
   assign rsp_active_flows     = active_ff;
   assign rsp_arrival_accepted = racc_ff;

   // Every slot handed out is either on the list or on the free stack
   `RRFS_ASSERT(a_slot_balance,
      (CW+1)'(count_ff) + (CW+1)'(free_top_ff) == (CW+1)'(fresh_ff),
      "slot accounting broken")
   `RRFS_ASSERT(a_count_bound, count_ff <= COUNT_MAX, "flow count above table size")
   `RRFS_ASSERT(a_no_send_fields,
      rsp_valid_ff && !sent_ff |-> tag_ff == 16'd0 && pnum_ff == 16'd0 && !done_ff,
      "idle result carries send fields")
   `RRFS_ASSERT(a_result_hold,
      $past(rsp_valid_ff && rsp_stall) |-> rsp_valid_ff && $stable(tag_ff)
      && $stable(pnum_ff), "stalled result changed")

endmodule

@@ design/round_robin_flow_scheduler_unit.sv @@
// Round-robin flow scheduler: top level with configuration registers.
//
// Requests (req_valid/req_stall) carry kind and flow_length. An arrival
// (kind 0) creates a flow, length capped at max_flow_length, unless the
// capped length is zero, the creation limit is reached or the table of
// MAX_ACTIVE flows is full. A transmit tick (kind 1) sends one packet of
// the flow under the serve pointer and moves the pointer around the list.
// Every request yields exactly one response (rsp_valid/rsp_stall).
// Steps from request accept to response: a refused arrival or an idle tick
// goes decode, finish; a queued arrival goes decode, insert, finish; a tick
// that sends goes decode, read (registered read of the flow RAMs), execute;
// an arrival into an empty list goes decode, insert, read, execute (it sends
// at once). One request is in flight at a time; the next can be taken once
// its response is registered. Reset empties the list and restores register
// defaults; no memory clear. A stalled response is held; the block then
// waits before its next result. Configuration (csr_valid/csr_ready, always
// ready) is written by the user only while idle; not enforced by the block.
module round_robin_flow_scheduler_unit
   import rrfs_pkg::*;
#(
   parameter int MAX_ACTIVE = MAX_ACTIVE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [15:0]                req_flow_length,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_sent,
   output logic [15:0]                rsp_flow_tag,
   output logic [15:0]                rsp_packet_number,
   output logic                       rsp_flow_done,
   output logic [4:0]                 rsp_active_flows,
   output logic                       rsp_arrival_accepted,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                csr_wdata
);

   logic        limit_enable_ff;
   logic [15:0] flow_limit_ff;
   logic [15:0] max_len_ff;
   cmd_type     cmd;
   status_type  st;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         flow_limit_ff   <= 16'd0;
         max_len_ff      <= MAX_FLOW_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LIMIT_ENABLE:    limit_enable_ff <= csr_wdata[0];
            CSR_FLOW_LIMIT:      flow_limit_ff   <= csr_wdata;
            CSR_MAX_FLOW_LENGTH: max_len_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   rrfs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .st(st), .cmd(cmd)
   );

   rrfs_datapath #(.MAX_ACTIVE(MAX_ACTIVE)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st),
      .req_kind(req_kind), .req_flow_length(req_flow_length),
      .limit_enable(limit_enable_ff), .flow_limit(flow_limit_ff),
      .max_flow_length(max_len_ff), .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .rsp_sent(rsp_sent), .rsp_flow_tag(rsp_flow_tag),
      .rsp_packet_number(rsp_packet_number), .rsp_flow_done(rsp_flow_done),
      .rsp_active_flows(rsp_active_flows), .rsp_arrival_accepted(rsp_arrival_accepted)
   );

endmodule
